// File: sv/ptg_pkg.sv
// Shared types, codes and arithmetic for the palette tint and gamma block.
package ptg_pkg;

  localparam int REG_COUNT   = 4;
  localparam int REG_IDX_W   = $clog2(REG_COUNT);
  localparam int CFG_INDEX_W = 8;
  localparam int TABLE_DEPTH = 256;

  localparam logic OP_TINT        = 1'b0;
  localparam logic OP_TABLE_WRITE = 1'b1;

  localparam logic KIND_COLOR = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] table_index;
    logic [7:0] table_value;
  } ptg_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } ptg_result_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            data;
  } ptg_cfg_t;

  function automatic logic [7:0] tint_channel(input logic [7:0] c,
                                               input logic [7:0] dest,
                                               input logic [7:0] pct);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    diff = $signed({1'b0, dest}) - $signed({1'b0, c});
    prod = $signed({1'b0, pct}) * diff;
    return c + prod[15:8];
  endfunction

endpackage

// File: sv/ptg_chan_if.sv
// Valid/ready channel interface carrying one payload of type T.
interface ptg_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/ptg_tint_stage.sv
// One registered tint stage: blend each channel towards the stage colour.
module ptg_tint_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         tint,
  input  logic                up_valid,
  input  ptg_pkg::ptg_item_t  up_item,
  output logic                up_ready,
  output logic                dn_valid,
  output ptg_pkg::ptg_item_t  dn_item,
  input  logic                dn_ready
);

  ptg_pkg::ptg_item_t tinted;

  always_comb begin
    tinted       = up_item;
    tinted.red   = ptg_pkg::tint_channel(up_item.red,   tint[7:0],   tint[31:24]);
    tinted.green = ptg_pkg::tint_channel(up_item.green, tint[15:8],  tint[31:24]);
    tinted.blue  = ptg_pkg::tint_channel(up_item.blue,  tint[23:16], tint[31:24]);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_item <= tinted;
    end
  end

endmodule

// File: sv/ptg_gamma_lut.sv
// Gamma table stage: three table copies, one per channel, with registered reads.
module ptg_gamma_lut (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  input  ptg_pkg::ptg_item_t   up_item,
  output logic                 up_ready,
  output logic                 res_valid,
  output ptg_pkg::ptg_result_t res_data,
  input  logic                 res_ready
);

  logic [7:0] mem_red   [ptg_pkg::TABLE_DEPTH];
  logic [7:0] mem_green [ptg_pkg::TABLE_DEPTH];
  logic [7:0] mem_blue  [ptg_pkg::TABLE_DEPTH];
  logic [ptg_pkg::TABLE_DEPTH-1:0] written;

  logic       kind;
  logic [7:0] data_red, data_green, data_blue;
  logic [7:0] addr_red, addr_green, addr_blue;
  logic       hit_red, hit_green, hit_blue;
  logic       take;
  logic       is_write;

  assign up_ready = !res_valid || res_ready;
  assign take     = up_valid && up_ready;
  assign is_write = up_item.operation == ptg_pkg::OP_TABLE_WRITE;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (up_ready) begin
      res_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (take && is_write) begin
      written[up_item.table_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_write) begin
      mem_red[up_item.table_index]   <= up_item.table_value;
      mem_green[up_item.table_index] <= up_item.table_value;
      mem_blue[up_item.table_index]  <= up_item.table_value;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind       <= is_write ? ptg_pkg::KIND_ACK : ptg_pkg::KIND_COLOR;
      data_red   <= mem_red[up_item.red];
      data_green <= mem_green[up_item.green];
      data_blue  <= mem_blue[up_item.blue];
      addr_red   <= up_item.red;
      addr_green <= up_item.green;
      addr_blue  <= up_item.blue;
      hit_red    <= written[up_item.red];
      hit_green  <= written[up_item.green];
      hit_blue   <= written[up_item.blue];
    end
  end

  always_comb begin
    res_data.out_kind = kind;
    if (kind == ptg_pkg::KIND_ACK) begin
      res_data.out_red   = '0;
      res_data.out_green = '0;
      res_data.out_blue  = '0;
    end else begin
      res_data.out_red   = hit_red   ? data_red   : addr_red;
      res_data.out_green = hit_green ? data_green : addr_green;
      res_data.out_blue  = hit_blue  ? data_blue  : addr_blue;
    end
  end

endmodule

// File: sv/palette_tint_gamma_top.sv
// Top level of the palette tint and gamma block.
// Takes one request per cycle while the result side is ready and returns one result per
// request, in order, through its tint stages and gamma read. Each tint stage holds one
// 8x9-bit multiply and add per channel; the last stage is the registered gamma table read.
// A table write request updates the entry as it passes the last stage, so it applies to
// every colour request behind it, and returns an acknowledgement with zero colour fields.
// The gamma table reads as identity after reset with no clearing pass. Tint registers
// 0..3 are written through cfg (always ready); higher indexes are dropped, and stages
// above the fourth leave the colour unchanged. Write cfg only while no request is in flight.
module palette_tint_gamma_top #(
  parameter int NUM_SHIFTS = 4
) (
  input  logic       clk,
  input  logic       rst,
  ptg_chan_if.sink   pixel,
  ptg_chan_if.source result,
  ptg_chan_if.sink   cfg
);

  logic [31:0] shift_reg [ptg_pkg::REG_COUNT];

  logic               stage_valid [NUM_SHIFTS+1];
  logic               stage_ready [NUM_SHIFTS+1];
  ptg_pkg::ptg_item_t stage_item  [NUM_SHIFTS+1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptg_pkg::REG_COUNT; i++) begin
        shift_reg[i] <= '0;
      end
    end else if (cfg.valid &&
                 cfg.data.index < ptg_pkg::CFG_INDEX_W'(ptg_pkg::REG_COUNT)) begin
      shift_reg[cfg.data.index[ptg_pkg::REG_IDX_W-1:0]] <= cfg.data.data;
    end
  end

  assign stage_valid[0] = pixel.valid;
  assign stage_item[0]  = pixel.data;
  assign pixel.ready    = stage_ready[0];

  for (genvar k = 0; k < NUM_SHIFTS; k++) begin : g_stage
    logic [31:0] tint;

    if (k < ptg_pkg::REG_COUNT) begin : g_reg
      assign tint = shift_reg[k];
    end else begin : g_none
      assign tint = '0;
    end

    ptg_tint_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .tint     (tint),
      .up_valid (stage_valid[k]),
      .up_item  (stage_item[k]),
      .up_ready (stage_ready[k]),
      .dn_valid (stage_valid[k+1]),
      .dn_item  (stage_item[k+1]),
      .dn_ready (stage_ready[k+1])
    );
  end

  ptg_gamma_lut u_gamma (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (stage_valid[NUM_SHIFTS]),
    .up_item   (stage_item[NUM_SHIFTS]),
    .up_ready  (stage_ready[NUM_SHIFTS]),
    .res_valid (result.valid),
    .res_data  (result.data),
    .res_ready (result.ready)
  );

endmodule

// File: sv/ptg_checker.sv
// Port-level checks for the palette tint and gamma block, bound to the top level.
module ptg_checker (
  input logic       clk,
  input logic       rst,
  input logic       pixel_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_kind,
  input logic [7:0] res_red,
  input logic [7:0] res_green,
  input logic [7:0] res_blue
);

  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid straight after reset");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_red)
                                && $stable(res_green) && $stable(res_blue))
    else $error("stalled result changed or dropped");

  assert property (@(posedge clk) disable iff (rst)
    res_ready |-> pixel_ready)
    else $error("input stalled while result side is ready");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == ptg_pkg::KIND_ACK |->
      res_red == 8'd0 && res_green == 8'd0 && res_blue == 8'd0)
    else $error("table write acknowledgement carries colour data");

endmodule

bind palette_tint_gamma_top ptg_checker u_ptg_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_ready (pixel.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_kind    (result.data.out_kind),
  .res_red     (result.data.out_red),
  .res_green   (result.data.out_green),
  .res_blue    (result.data.out_blue)
);

// File: verif/ptg_colour_checker.sv
// Checker for the palette tint and gamma block: predicts each result and compares it on arrival.
`timescale 1ns / 1ps

module ptg_colour_checker #(
  parameter int NUM_SHIFTS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  input  logic                 pixel_ready,
  input  ptg_pkg::ptg_item_t   pixel_data,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  ptg_pkg::ptg_result_t result_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  ptg_pkg::ptg_cfg_t    cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  logic [31:0]          tint_cfg [ptg_pkg::REG_COUNT];
  logic [7:0]           gamma_shadow [ptg_pkg::TABLE_DEPTH];
  ptg_pkg::ptg_result_t awaited [$];
  int                   mismatches = 0;

  function automatic logic [7:0] tinted(input logic [7:0] c, input logic [7:0] dest,
                                        input logic [7:0] pct);
    int diff;
    int prod;
    diff = int'(dest) - int'(c);
    prod = int'(pct) * diff;
    return 8'(int'(c) + (prod >>> 8));
  endfunction

  function automatic ptg_pkg::ptg_result_t predict_colour(input ptg_pkg::ptg_item_t req);
    ptg_pkg::ptg_result_t res;
    logic [7:0]           r, g, b, pct;
    logic [31:0]          stage;
    res = '0;
    if (req.operation == ptg_pkg::OP_TABLE_WRITE) begin
      res.out_kind = ptg_pkg::KIND_ACK;
      return res;
    end
    r = req.red;
    g = req.green;
    b = req.blue;
    for (int s = 0; s < NUM_SHIFTS; s++) begin
      if (s < ptg_pkg::REG_COUNT) begin
        stage = tint_cfg[s];
        pct   = stage[31:24];
        r     = tinted(r, stage[7:0], pct);
        g     = tinted(g, stage[15:8], pct);
        b     = tinted(b, stage[23:16], pct);
      end
    end
    res.out_kind  = ptg_pkg::KIND_COLOR;
    res.out_red   = gamma_shadow[r];
    res.out_green = gamma_shadow[g];
    res.out_blue  = gamma_shadow[b];
    return res;
  endfunction

  always @(posedge clk) begin
    ptg_pkg::ptg_result_t want;
    if (rst) begin
      foreach (tint_cfg[i]) tint_cfg[i] = '0;
      foreach (gamma_shadow[i]) gamma_shadow[i] = 8'(i);
      awaited.delete();
      mismatches = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result kind %0d rgb %02h %02h %02h", $realtime,
                     result_data.out_kind, result_data.out_red, result_data.out_green,
                     result_data.out_blue);
        end else begin
          want = awaited.pop_front();
          if (result_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch: expected kind %0d rgb %02h %02h %02h, ",
                        "got kind %0d rgb %02h %02h %02h"},
                       $realtime, want.out_kind, want.out_red, want.out_green, want.out_blue,
                       result_data.out_kind, result_data.out_red, result_data.out_green,
                       result_data.out_blue);
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_data.index < ptg_pkg::REG_COUNT)
        tint_cfg[cfg_data.index[ptg_pkg::REG_IDX_W-1:0]] = cfg_data.data;
      if (pixel_valid && pixel_ready) begin
        awaited.push_back(predict_colour(pixel_data));
        if (pixel_data.operation == ptg_pkg::OP_TABLE_WRITE)
          gamma_shadow[pixel_data.table_index] = pixel_data.table_value;
      end
    end
    fail_count  <= mismatches;
    outstanding <= awaited.size();
  end

endmodule

// File: verif/testbench.sv
// Stimulus and verdict for the palette tint and gamma block.
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_SHIFTS  = 4;
  localparam int LATENCY     = NUM_SHIFTS + 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SEGMENTS    = 6;
  localparam int SEG_ITEMS   = 105;

  logic clk;
  logic rst;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   fail_count;
  int   outstanding;
  int   cycles = 0;

  ptg_chan_if #(.T(ptg_pkg::ptg_item_t))   pixel_ch ();
  ptg_chan_if #(.T(ptg_pkg::ptg_result_t)) result_ch ();
  ptg_chan_if #(.T(ptg_pkg::ptg_cfg_t))    cfg_ch ();

  palette_tint_gamma_top #(.NUM_SHIFTS(NUM_SHIFTS)) dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  ptg_colour_checker #(.NUM_SHIFTS(NUM_SHIFTS)) colour_check (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_ch.valid),
    .pixel_ready  (pixel_ch.ready),
    .pixel_data   (pixel_ch.data),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .result_data  (result_ch.data),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_data     (cfg_ch.data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic ptg_pkg::ptg_item_t colour_request(input logic [7:0] r,
                                                        input logic [7:0] g,
                                                        input logic [7:0] b);
    return '{ptg_pkg::OP_TINT, r, g, b, 8'($urandom), 8'($urandom)};
  endfunction

  function automatic ptg_pkg::ptg_item_t table_request(input logic [7:0] idx,
                                                       input logic [7:0] val);
    return '{ptg_pkg::OP_TABLE_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), idx, val};
  endfunction

  function automatic logic [7:0] end_value();
    return $urandom_range(1) ? 8'hff : 8'h00;
  endfunction

  function automatic logic [31:0] random_tint();
    case ($urandom_range(3))
      0: return {end_value(), end_value(), end_value(), end_value()};
      1: return {8'h00, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input ptg_pkg::ptg_item_t req);
    while ($urandom_range(99) < send_idle) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.data  <= req;
    do @(posedge clk); while (!pixel_ch.ready);
  endtask

  // hold off until every request has come back
  task automatic settle();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  task automatic program_tints(input logic [31:0] tint [ptg_pkg::REG_COUNT]);
    for (int i = 0; i <= ptg_pkg::REG_COUNT; i++) begin
      cfg_ch.valid <= 1'b1;
      if (i < ptg_pkg::REG_COUNT)
        cfg_ch.data <= '{ptg_pkg::CFG_INDEX_W'(i), tint[i]};
      else
        cfg_ch.data <= '{ptg_pkg::CFG_INDEX_W'($urandom_range(255, ptg_pkg::REG_COUNT)),
                         32'($urandom)};
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] tint [ptg_pkg::REG_COUNT];
    pixel_ch.valid <= 1'b0;
    pixel_ch.data  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset tints and identity table
    send_request(colour_request(8'h00, 8'h00, 8'h00));
    send_request(colour_request(8'hff, 8'hff, 8'hff));
    send_request(colour_request(8'h5a, 8'ha5, 8'h0f));
    send_request(table_request(8'h00, 8'hff));
    send_request(table_request(8'hff, 8'h00));
    send_request(table_request(8'h80, 8'h07));
    send_request(colour_request(8'h00, 8'hff, 8'h80));
    send_request(colour_request(8'hff, 8'h00, 8'h00));
    settle();

    tint[0] = {8'hff, 8'hff, 8'h00, 8'hff};
    tint[1] = {8'h80, 8'h00, 8'hff, 8'h00};
    tint[2] = {8'h01, 8'h11, 8'hc8, 8'h63};
    tint[3] = 32'hffff_ffff;
    program_tints(tint);
    send_request(colour_request(8'h00, 8'h00, 8'h00));
    send_request(colour_request(8'hff, 8'hff, 8'hff));
    send_request(colour_request(8'h00, 8'hff, 8'h00));
    send_request(colour_request(8'hff, 8'h00, 8'hff));
    send_request(colour_request(8'h01, 8'hfe, 8'h80));
    settle();

    tint[0] = {8'hff, 8'h00, 8'h00, 8'h00};
    tint[1] = 32'h0;
    tint[2] = {8'h80, 8'hff, 8'h00, 8'hff};
    tint[3] = {8'h7f, 8'h40, 8'h20, 8'h10};
    program_tints(tint);
    send_request(colour_request(8'hff, 8'hff, 8'hff));
    send_request(colour_request(8'h00, 8'h80, 8'h01));
    send_request(colour_request(8'h7f, 8'h00, 8'hff));
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      send_idle = (seg < 2) ? 32 : ((seg < 4) ? 85 : 0);
      recv_idle = (seg < 2) ? 85 : ((seg < 4) ? 32 : 0);
      foreach (tint[i]) tint[i] = random_tint();
      program_tints(tint);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(99) < 2)
          settle();
        if ($urandom_range(99) < 20)
          send_request(table_request(8'($urandom), 8'($urandom)));
        else
          send_request(colour_request(8'($urandom), 8'($urandom), 8'($urandom)));
      end
      settle();
    end

    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
